// ===== sv/bblur_pkg.sv =====
// ----------------------------------------------------------------------------
// bblur_pkg
// shared types, constants and divider helpers for the 3x3 box blur
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bblur_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam int FRAME_WIDTH_RESET  = 640;
	localparam int FRAME_HEIGHT_RESET = 480;

	// pixel and sum widths
	localparam int CH_W    = 8;
	localparam int NUM_CH  = 3;
	localparam int PIX_W   = NUM_CH * CH_W;
	localparam int POS_W   = 11;
	localparam int CSUM2_W = 9;
	localparam int CSUM3_W = 10;
	localparam int SUM_W   = 12;
	localparam int T_W     = 13;
	localparam int RECIP_W = 14;
	localparam int PROD_W  = T_W + RECIP_W;
	localparam int RECIP_SHIFT = 16;

	// result slots one input word can cause, in delivery order
	localparam int NUM_RES        = 4;
	localparam int RES_ABOVE_LEFT = 0;
	localparam int RES_LEFT       = 1;
	localparam int RES_ABOVE      = 2;
	localparam int RES_HERE       = 3;

	typedef enum logic [1:0] {
		DIV_4,
		DIV_6,
		DIV_9
	} div_t;

	// neighbor count of the mean
	function automatic logic [3:0] div_count(input div_t d);
		case (d)
			DIV_4:   return 4'd4;
			DIV_6:   return 4'd6;
			DIV_9:   return 4'd9;
			default: return 4'd4;
		endcase
	endfunction

	// ceil(2^16 / (2n)), exact for every reachable numerator
	function automatic logic [RECIP_W-1:0] div_recip(input div_t d);
		case (d)
			DIV_4:   return 14'd8192;
			DIV_6:   return 14'd5462;
			DIV_9:   return 14'd3641;
			default: return 14'd8192;
		endcase
	endfunction

	typedef struct packed {
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0]  out_red;
		logic [CH_W-1:0]  out_green;
		logic [CH_W-1:0]  out_blue;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             run_last;
		logic             frame_done;
	} result_t;

	// one new window column plus the position info of the word behind it
	typedef struct packed {
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] middle;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             has_result;
		logic             last_row;
		logic             last_col;
		logic             rows3;
		logic             cols3;
	} win_load_t;

	typedef struct packed {
		logic emit;
		logic ready;
	} win_stat_t;

endpackage

// ===== sv/bblur_stream_if.sv =====
// ----------------------------------------------------------------------------
// bblur_stream_if
// valid/ready stream channel carrying one payload word per handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bblur_stream_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ===== sv/bblur_line_buf.sv =====
// ----------------------------------------------------------------------------
// bblur_line_buf
// two line stores packed side by side, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bblur_line_buf import bblur_pkg::*; #(
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [2*PIX_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [2*PIX_W-1:0] wr_data
);

	// word layout: {two rows back, one row back}
	logic [2*PIX_W-1:0] mem_q [DEPTH];
	logic [2*PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/bblur_mean.sv =====
// ----------------------------------------------------------------------------
// bblur_mean
// rounded mean of 4, 6 or 9 pixels from column sums, one channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bblur_mean import bblur_pkg::*; (
	input  logic [2:0][CSUM3_W-1:0] col_sum,
	input  logic                    use_col0,
	input  div_t                    div_sel,
	output logic [CH_W-1:0]         mean
);

	logic [SUM_W-1:0]  sum;
	logic [T_W-1:0]    numer;
	logic [PROD_W-1:0] prod;

	assign sum = (use_col0 ? SUM_W'(col_sum[0]) : SUM_W'(0))
		+ SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);

	// (2*sum + n) / (2n) by reciprocal multiply
	assign numer = {sum, 1'b0} + T_W'(div_count(div_sel));
	assign prod  = PROD_W'(numer) * PROD_W'(div_recip(div_sel));
	assign mean  = prod[RECIP_SHIFT +: CH_W];

endmodule

// ===== sv/bblur_window.sv =====
// ----------------------------------------------------------------------------
// bblur_window
// 3x3 window held as column sums, and the sequencer that hands out results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bblur_window import bblur_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  win_load_t load_info,
	input  logic      out_free,
	output win_stat_t stat,
	output result_t   res
);

	// per column: sum of all three rows, and of the lower two rows
	logic [2:0][NUM_CH-1:0][CSUM3_W-1:0] sum3_q;
	logic [2:0][NUM_CH-1:0][CSUM2_W-1:0] sum2_q;
	logic [NUM_CH-1:0][CSUM3_W-1:0]      new3;
	logic [NUM_CH-1:0][CSUM2_W-1:0]      new2;

	logic [NUM_RES-1:0] pend_q;
	logic [NUM_RES-1:0] new_pend;
	logic [NUM_RES-1:0] pick;
	logic [NUM_RES-1:0] rest;
	logic               rows3_q;
	logic               cols3_q;
	logic [POS_W-1:0]   row_q;
	logic [POS_W-1:0]   col_q;

	logic prev_row;
	logic prev_col;
	logic use_rows3;
	logic use_col0;
	logic emit;
	div_t div_sel;

	logic [NUM_CH-1:0][2:0][CSUM3_W-1:0] mean_in;
	logic [NUM_CH-1:0][CH_W-1:0]         mean_out;

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			new2[ch] = CSUM2_W'(load_info.middle[PIX_W-1-CH_W*ch -: CH_W])
				+ CSUM2_W'(load_info.px[PIX_W-1-CH_W*ch -: CH_W]);
			new3[ch] = CSUM3_W'(load_info.upper[PIX_W-1-CH_W*ch -: CH_W])
				+ CSUM3_W'(new2[ch]);
		end
	end

	always_comb begin
		new_pend = '0;
		new_pend[RES_ABOVE_LEFT] = load_info.has_result;
		new_pend[RES_LEFT]       = load_info.has_result && load_info.last_row;
		new_pend[RES_ABOVE]      = load_info.has_result && load_info.last_col;
		new_pend[RES_HERE]       = load_info.has_result && load_info.last_row
			&& load_info.last_col;
	end

	// lowest pending slot goes out first
	assign pick = pend_q & (~pend_q + NUM_RES'(1));
	assign rest = pend_q & ~pick;

	assign prev_row  = pick[RES_ABOVE_LEFT] | pick[RES_ABOVE];
	assign prev_col  = pick[RES_ABOVE_LEFT] | pick[RES_LEFT];
	assign use_rows3 = rows3_q & prev_row;
	assign use_col0  = cols3_q & prev_col;

	always_comb begin
		case ({use_rows3, use_col0})
			2'b11:   div_sel = DIV_9;
			2'b00:   div_sel = DIV_4;
			default: div_sel = DIV_6;
		endcase
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int j = 0; j < 3; j++) begin
				mean_in[ch][j] = use_rows3 ? sum3_q[j][ch] : CSUM3_W'(sum2_q[j][ch]);
			end
		end
	end

	for (genvar g = 0; g < NUM_CH; g++) begin : g_mean
		bblur_mean u_mean (
			.col_sum  (mean_in[g]),
			.use_col0 (use_col0),
			.div_sel  (div_sel),
			.mean     (mean_out[g])
		);
	end

	assign emit       = (pend_q != '0) && out_free;
	assign stat.emit  = emit;
	assign stat.ready = (pend_q == '0) || (out_free && (rest == '0));

	assign res.out_red    = mean_out[0];
	assign res.out_green  = mean_out[1];
	assign res.out_blue   = mean_out[2];
	assign res.out_row    = prev_row ? row_q - POS_W'(1) : row_q;
	assign res.out_col    = prev_col ? col_q - POS_W'(1) : col_q;
	assign res.run_last   = (rest == '0);
	assign res.frame_done = pick[RES_HERE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			rows3_q <= 1'b0;
			cols3_q <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			sum3_q  <= '0;
			sum2_q  <= '0;
		end else if (load) begin
			pend_q    <= new_pend;
			rows3_q   <= load_info.rows3;
			cols3_q   <= load_info.cols3;
			row_q     <= load_info.row;
			col_q     <= load_info.col;
			sum3_q[0] <= sum3_q[1];
			sum3_q[1] <= sum3_q[2];
			sum3_q[2] <= new3;
			sum2_q[0] <= sum2_q[1];
			sum2_q[1] <= sum2_q[2];
			sum2_q[2] <= new2;
		end else if (emit) begin
			pend_q <= rest;
		end
	end

endmodule

// ===== sv/box_blur_3x3_edge_aware.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// path: an accepted word passes stage 1, the window and the output register
// throughput: 1 word per cycle unless the output stalls; a word at a row end or in
//   the last row makes 2 to 4 results and holds the input (one output port)
// reset: async active-low, clears control, position and frame size (640x480);
//   line stores are not cleared, so no clearing pass is needed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware import bblur_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bblur_stream_if.sink          pixel,
	bblur_stream_if.source        blur,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// position counter widths
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int DIM_W = (CW > RW ? CW : RW) + 1;
	localparam int CLW   = DIM_W > CFG_DATA_W ? DIM_W : CFG_DATA_W;
	localparam int RST_W = FRAME_WIDTH_RESET > MAX_WIDTH ? MAX_WIDTH : FRAME_WIDTH_RESET;
	localparam int RST_H = FRAME_HEIGHT_RESET > MAX_HEIGHT ? MAX_HEIGHT : FRAME_HEIGHT_RESET;

	// clamp a written size to 2..hi and turn it into the last index
	function automatic logic [CLW-1:0] clamp_last(
		input logic [CFG_DATA_W-1:0] v,
		input logic [CLW-1:0]        hi
	);
		logic [CLW-1:0] x;
		x = CLW'(v);
		if (x < CLW'(2)) begin
			x = CLW'(2);
		end else if (x > hi) begin
			x = hi;
		end
		return x - CLW'(1);
	endfunction

	// frame geometry, kept as last column / last row index
	logic [CW-1:0]  last_col_q;
	logic [RW-1:0]  last_row_q;
	logic [CLW-1:0] cfg_last_w;
	logic [CLW-1:0] cfg_last_h;

	// raster position of the next input word
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW+POS_W-1:0] col_ext;
	logic [RW+POS_W-1:0] row_ext;

	// stage 1: accepted word waiting for its line store read data
	logic             s1_valid_q;
	logic [PIX_W-1:0] px_s1;
	logic [CW-1:0]    addr_s1;
	logic [POS_W-1:0] row_s1;
	logic [POS_W-1:0] col_s1;
	logic             has_s1;
	logic             last_row_s1;
	logic             last_col_s1;
	logic             rows3_s1;
	logic             cols3_s1;

	logic               accept;
	logic               s1_move;
	logic [2*PIX_W-1:0] line_rd;
	win_load_t          win_load;
	win_stat_t          win_stat;
	result_t            win_res;

	// output register
	logic    out_valid_q;
	result_t result_q;
	logic    out_free;

	assign cfg_last_w = clamp_last(cfg_data, CLW'(MAX_WIDTH));
	assign cfg_last_h = clamp_last(cfg_data, CLW'(MAX_HEIGHT));

	// input side: take a word whenever stage 1 is empty or moves on this cycle
	assign accept      = pixel.valid && pixel.ready;
	assign s1_move     = s1_valid_q && win_stat.ready;
	assign pixel.ready = !s1_valid_q || s1_move;

	// result positions are reported modulo 2048
	assign col_ext = (CW + POS_W)'(col_q);
	assign row_ext = (RW + POS_W)'(row_q);

	// config writes restart the frame; raster counters step per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= CW'(RST_W - 1);
			last_row_q <= RW'(RST_H - 1);
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FRAME_WIDTH: begin
					last_col_q <= cfg_last_w[CW-1:0];
					col_q      <= '0;
					row_q      <= '0;
				end
				REG_FRAME_HEIGHT: begin
					last_row_q <= cfg_last_h[RW-1:0];
					col_q      <= '0;
					row_q      <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (col_q == last_col_q) begin
				col_q <= '0;
				row_q <= (row_q == last_row_q) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload: pixel, position and which results it will cause
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= {pixel.data.in_red, pixel.data.in_green, pixel.data.in_blue};
			addr_s1     <= col_q;
			row_s1      <= row_ext[POS_W-1:0];
			col_s1      <= col_ext[POS_W-1:0];
			has_s1      <= (row_q != '0) && (col_q != '0);
			last_row_s1 <= (row_q == last_row_q);
			last_col_s1 <= (col_q == last_col_q);
			rows3_s1    <= (row_q > RW'(1));
			cols3_s1    <= (col_q > CW'(1));
		end
	end

	// line stores: read this column at accept, write it back when stage 1
	// moves on (upper takes the old middle, middle takes the new pixel);
	// consecutive words never share a column since the width is at least 2
	bblur_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (line_rd),
		.wr_en   (s1_move),
		.wr_addr (addr_s1),
		.wr_data ({line_rd[PIX_W-1:0], px_s1})
	);

	always_comb begin
		win_load.px         = px_s1;
		win_load.upper      = line_rd[2*PIX_W-1:PIX_W];
		win_load.middle     = line_rd[PIX_W-1:0];
		win_load.row        = row_s1;
		win_load.col        = col_s1;
		win_load.has_result = has_s1;
		win_load.last_row   = last_row_s1;
		win_load.last_col   = last_col_s1;
		win_load.rows3      = rows3_s1;
		win_load.cols3      = cols3_s1;
	end

	// window and result sequencer: loads a new column when its last pending
	// result goes out (or none is pending), one result per free output slot
	bblur_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_move),
		.load_info (win_load),
		.out_free  (out_free),
		.stat      (win_stat),
		.res       (win_res)
	);

	// output register parts the result port from the window
	assign out_free = !out_valid_q || blur.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (win_stat.emit) begin
			out_valid_q <= 1'b1;
		end else if (blur.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (win_stat.emit) begin
			result_q <= win_res;
		end
	end

	assign blur.valid = out_valid_q;
	assign blur.data  = result_q;

`ifndef NO_ASSERTIONS
	// the bottom right pixel is always the last result of its word
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.frame_done |-> result_q.run_last)
		else $error("frame_done without run_last");

	// raster position never runs past the configured frame
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= last_col_q) && (row_q <= last_row_q))
		else $error("raster position outside frame");

	// a word in stage 1 is never dropped while the window is busy
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_move |=> s1_valid_q)
		else $error("stage 1 word lost");
`endif

endmodule
